### hw/rtl/jfsp_pkg.sv
// Shared types, codes and header table for the JPEG frame size parser.
package jfsp_pkg;

    localparam int DATA_W      = 8;
    localparam int DIM_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;

    localparam logic [3:0] HDR_LEN_HI_POS = 4'd4;
    localparam logic [3:0] HDR_LEN_LO_POS = 4'd5;
    localparam logic [3:0] HDR_LAST_POS   = 4'd10;
    localparam logic [2:0] SOF_HEIGHT_HI  = 3'd3;
    localparam logic [2:0] SOF_HEIGHT_LO  = 3'd4;
    localparam logic [2:0] SOF_WIDTH_HI   = 3'd5;
    localparam logic [2:0] SOF_WIDTH_LO   = 3'd6;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] SOF_FIRST     = 8'hC0;
    localparam logic [7:0] SOF_LAST      = 8'hCF;
    localparam logic [7:0] DHT_ID        = 8'hC4;
    localparam logic [7:0] JPG_ID        = 8'hC8;
    localparam logic [7:0] DAC_ID        = 8'hCC;

    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_SKIP    = 8'b0000_0010,
        PH_MARK_FF = 8'b0000_0100,
        PH_MARK_ID = 8'b0000_1000,
        PH_LEN_HI  = 8'b0001_0000,
        PH_LEN_LO  = 8'b0010_0000,
        PH_FRAME   = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND   = 3'd0,
        ST_BAD_SOI = 3'd1,
        ST_NO_JFIF = 3'd2,
        ST_NO_MARK = 3'd3,
        ST_ENDED   = 3'd4
    } status_t;

    typedef struct packed {
        phase_t             phase;
        logic [3:0]         hdr_pos;
        logic [DIM_W-1:0]   skip;
        logic [DATA_W-1:0]  len_hi;
        logic [2:0]         frame_idx;
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   width;
    } parse_state_t;

    typedef struct packed {
        logic               emit;
        status_t            status;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:     PH_HEADER,
        hdr_pos:   4'd0,
        skip:      '0,
        len_hi:    '0,
        frame_idx: 3'd0,
        height:    '0,
        width:     '0
    };

    function automatic logic [7:0] hdr_expect(input logic [3:0] pos);
        case (pos)
            4'd0:    hdr_expect = 8'hFF;
            4'd1:    hdr_expect = 8'hD8;
            4'd2:    hdr_expect = 8'hFF;
            4'd3:    hdr_expect = 8'hE0;
            4'd6:    hdr_expect = 8'h4A;
            4'd7:    hdr_expect = 8'h46;
            4'd8:    hdr_expect = 8'h49;
            4'd9:    hdr_expect = 8'h46;
            default: hdr_expect = 8'h00;
        endcase
    endfunction

    function automatic logic is_sof(input logic [7:0] m);
        is_sof = (m >= SOF_FIRST) && (m <= SOF_LAST) &&
                 (m != DHT_ID) && (m != JPG_ID) && (m != DAC_ID);
    endfunction

endpackage

### hw/rtl/jpeg_frame_size_parser.sv
// Top level of the JPEG frame size parser: input register, parse step, result register.
// The parse step is a single pass between registers; m_tvalid rises when the result
// register takes the deciding beat. Throughput: one byte per cycle unless stalled.
// Back-pressure on the result side stalls the input register and then s_tready.
// Reset: aresetn low clears the parse state and both valid flags synchronously.
// The parse state also rearms on every beat with tlast high.
module jpeg_frame_size_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [jfsp_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jfsp_pkg::M_TDATA_W-1:0]    m_tdata    // [2:0] status, [18:3] image_width,
                                                         // [34:19] image_height, [39:35] zero
);

    logic                              in_valid_reg;
    logic [jfsp_pkg::DATA_W-1:0]       in_byte_reg;
    logic                              in_last_reg;
    logic                              advance;
    jfsp_pkg::parse_state_t            state_reg;
    jfsp_pkg::parse_state_t            state_next;
    jfsp_pkg::parse_result_t           step_res;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [jfsp_pkg::M_TDATA_W-1:0]    out_data_reg;

    assign advance        = !out_valid_reg || m_tready;
    assign s_tready       = !in_valid_reg || advance;
    assign out_valid_next = advance ? (in_valid_reg && step_res.emit) : out_valid_reg;

    jfsp_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= jfsp_pkg::STATE_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance && in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[jfsp_pkg::DATA_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (advance && in_valid_reg && step_res.emit) begin
            out_data_reg <= {5'd0, step_res.height, step_res.width, step_res.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hw/rtl/jfsp_step.sv
// Per-byte parse step: next state and result for one input byte.
module jfsp_step (
    input  jfsp_pkg::parse_state_t           cur,
    input  logic [jfsp_pkg::DATA_W-1:0]      data_byte,
    input  logic                             last_byte,
    output jfsp_pkg::parse_state_t           nxt,
    output jfsp_pkg::parse_result_t          res
);

    logic [3:0]                  pos;
    logic [jfsp_pkg::DIM_W-1:0]  seg_len;

    assign pos     = (cur.hdr_pos > jfsp_pkg::HDR_LAST_POS) ? jfsp_pkg::HDR_LAST_POS
                                                            : cur.hdr_pos;
    assign seg_len = {cur.len_hi, data_byte};

    always_comb begin
        nxt        = cur;
        res.emit   = 1'b0;
        res.status = jfsp_pkg::ST_ENDED;
        res.width  = '0;
        res.height = '0;

        if (cur.phase != jfsp_pkg::PH_DONE) begin
            case (cur.phase)
                jfsp_pkg::PH_HEADER: begin
                    if (pos < jfsp_pkg::HDR_LEN_HI_POS) begin
                        if (data_byte != jfsp_pkg::hdr_expect(pos)) begin
                            res.emit   = 1'b1;
                            res.status = jfsp_pkg::ST_BAD_SOI;
                        end
                    end else if (pos == jfsp_pkg::HDR_LEN_HI_POS) begin
                        nxt.len_hi = data_byte;
                    end else if (pos == jfsp_pkg::HDR_LEN_LO_POS) begin
                        nxt.skip = seg_len;
                    end else if (data_byte != jfsp_pkg::hdr_expect(pos)) begin
                        res.emit   = 1'b1;
                        res.status = jfsp_pkg::ST_NO_JFIF;
                    end else if (pos == jfsp_pkg::HDR_LAST_POS) begin
                        if (cur.skip < 16'd7) begin
                            res.emit   = 1'b1;
                            res.status = jfsp_pkg::ST_NO_MARK;
                        end else begin
                            nxt.skip  = cur.skip - 16'd7;
                            nxt.phase = (cur.skip == 16'd7) ? jfsp_pkg::PH_MARK_FF
                                                            : jfsp_pkg::PH_SKIP;
                        end
                    end
                    nxt.hdr_pos = pos + 4'd1;
                end
                jfsp_pkg::PH_SKIP: begin
                    nxt.skip = cur.skip - 16'd1;
                    if (cur.skip == 16'd1) begin
                        nxt.phase = jfsp_pkg::PH_MARK_FF;
                    end
                end
                jfsp_pkg::PH_MARK_FF: begin
                    if (data_byte != jfsp_pkg::MARKER_PREFIX) begin
                        res.emit   = 1'b1;
                        res.status = jfsp_pkg::ST_NO_MARK;
                    end else begin
                        nxt.phase = jfsp_pkg::PH_MARK_ID;
                    end
                end
                jfsp_pkg::PH_MARK_ID: begin
                    if (jfsp_pkg::is_sof(data_byte)) begin
                        nxt.frame_idx = 3'd0;
                        nxt.height    = '0;
                        nxt.width     = '0;
                        nxt.phase     = jfsp_pkg::PH_FRAME;
                    end else begin
                        nxt.phase = jfsp_pkg::PH_LEN_HI;
                    end
                end
                jfsp_pkg::PH_LEN_HI: begin
                    nxt.len_hi = data_byte;
                    nxt.phase  = jfsp_pkg::PH_LEN_LO;
                end
                jfsp_pkg::PH_LEN_LO: begin
                    if (seg_len < 16'd2) begin
                        res.emit   = 1'b1;
                        res.status = jfsp_pkg::ST_NO_MARK;
                    end else begin
                        nxt.skip  = seg_len - 16'd2;
                        nxt.phase = (seg_len == 16'd2) ? jfsp_pkg::PH_MARK_FF
                                                       : jfsp_pkg::PH_SKIP;
                    end
                end
                jfsp_pkg::PH_FRAME: begin
                    if (cur.frame_idx == jfsp_pkg::SOF_HEIGHT_HI ||
                        cur.frame_idx == jfsp_pkg::SOF_HEIGHT_LO) begin
                        nxt.height = {cur.height[7:0], data_byte};
                    end else if (cur.frame_idx == jfsp_pkg::SOF_WIDTH_HI ||
                                 cur.frame_idx >= jfsp_pkg::SOF_WIDTH_LO) begin
                        nxt.width = {cur.width[7:0], data_byte};
                    end
                    if (cur.frame_idx >= jfsp_pkg::SOF_WIDTH_LO) begin
                        res.emit   = 1'b1;
                        res.status = jfsp_pkg::ST_FOUND;
                        res.height = cur.height;
                        res.width  = nxt.width;
                    end
                    nxt.frame_idx = cur.frame_idx + 3'd1;
                end
                default: begin
                end
            endcase

            if (res.emit) begin
                nxt.phase = jfsp_pkg::PH_DONE;
            end else if (last_byte) begin
                res.emit   = 1'b1;
                res.status = jfsp_pkg::ST_ENDED;
            end
        end

        if (last_byte) begin
            nxt = jfsp_pkg::STATE_RESET;
        end
    end

endmodule

### hw/rtl/jfsp_checker.sv
// Port-level checker for the JPEG frame size parser, bound to the top level.
module jfsp_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [jfsp_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [jfsp_pkg::M_TDATA_W-1:0]    m_tdata
);

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable({s_tdata, s_tlast}))
        else $error("stalled input beat changed");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == jfsp_pkg::ST_FOUND ||
                      m_tdata[2:0] == jfsp_pkg::ST_BAD_SOI ||
                      m_tdata[2:0] == jfsp_pkg::ST_NO_JFIF ||
                      m_tdata[2:0] == jfsp_pkg::ST_NO_MARK ||
                      m_tdata[2:0] == jfsp_pkg::ST_ENDED))
        else $error("status out of range");

    a_sizes_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != jfsp_pkg::ST_FOUND) |-> (m_tdata[39:3] == 37'd0))
        else $error("sizes not zero on failed parse");

endmodule

bind jpeg_frame_size_parser jfsp_checker u_jfsp_checker (.*);

### tb/jpeg_frame_size_parser_test.sv
// Testbench for the JPEG frame size parser: streamed JPEG byte files checked against a predictor.
`timescale 1ns / 100ps

typedef struct packed {
    jfsp_pkg::status_t status;
    logic [15:0]       width;
    logic [15:0]       height;
} frame_size_t;

class size_checker;
    localparam logic [87:0] START_SEQ = 88'hFF_D8_FF_E0_00_00_4A_46_49_46_00;

    jfsp_pkg::phase_t phase;
    logic [3:0]       hdr_pos;
    logic [15:0]      skip_left;
    logic [7:0]       len_hi;
    logic [2:0]       sof_idx;
    logic [15:0]      height_acc;
    logic [15:0]      width_acc;
    bit               done;
    frame_size_t      expected_sizes[$];
    int               errors;

    function new();
        errors = 0;
        rearm();
    endfunction

    function void rearm();
        phase      = jfsp_pkg::PH_HEADER;
        hdr_pos    = 4'd0;
        skip_left  = 16'd0;
        len_hi     = 8'd0;
        sof_idx    = 3'd0;
        height_acc = 16'd0;
        width_acc  = 16'd0;
        done       = 1'b0;
    endfunction

    function bit is_frame_marker(logic [7:0] m);
        return (m[7:4] == 4'hC) && ((m[3:0] == 4'h0) || (m[1:0] != 2'b00));
    endfunction

    function void take_byte(logic [7:0] b, logic last);
        bit                emit;
        jfsp_pkg::status_t st;
        logic [15:0]       w;
        logic [15:0]       h;
        logic [3:0]        pos;
        logic [15:0]       seg_len;
        logic [7:0]        want;
        frame_size_t       rec;
        emit = 1'b0;
        st   = jfsp_pkg::ST_ENDED;
        w    = 16'd0;
        h    = 16'd0;
        if (!done) begin
            case (phase)
                jfsp_pkg::PH_HEADER: begin
                    pos  = (hdr_pos > 4'd10) ? 4'd10 : hdr_pos;
                    want = START_SEQ[8 * (10 - int'(pos)) +: 8];
                    if (pos < 4'd4) begin
                        if (b != want) begin
                            emit = 1'b1;
                            st   = jfsp_pkg::ST_BAD_SOI;
                        end
                    end else if (pos == 4'd4) begin
                        len_hi = b;
                    end else if (pos == 4'd5) begin
                        skip_left = {len_hi, b};
                    end else if (b != want) begin
                        emit = 1'b1;
                        st   = jfsp_pkg::ST_NO_JFIF;
                    end else if (pos == 4'd10) begin
                        if (skip_left < 16'd7) begin
                            emit = 1'b1;
                            st   = jfsp_pkg::ST_NO_MARK;
                        end else begin
                            skip_left = skip_left - 16'd7;
                            phase     = (skip_left == 16'd0) ? jfsp_pkg::PH_MARK_FF
                                                             : jfsp_pkg::PH_SKIP;
                        end
                    end
                    hdr_pos = pos + 4'd1;
                end
                jfsp_pkg::PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0) phase = jfsp_pkg::PH_MARK_FF;
                end
                jfsp_pkg::PH_MARK_FF: begin
                    if (b != 8'hFF) begin
                        emit = 1'b1;
                        st   = jfsp_pkg::ST_NO_MARK;
                    end else begin
                        phase = jfsp_pkg::PH_MARK_ID;
                    end
                end
                jfsp_pkg::PH_MARK_ID: begin
                    if (is_frame_marker(b)) begin
                        sof_idx    = 3'd0;
                        height_acc = 16'd0;
                        width_acc  = 16'd0;
                        phase      = jfsp_pkg::PH_FRAME;
                    end else begin
                        phase = jfsp_pkg::PH_LEN_HI;
                    end
                end
                jfsp_pkg::PH_LEN_HI: begin
                    len_hi = b;
                    phase  = jfsp_pkg::PH_LEN_LO;
                end
                jfsp_pkg::PH_LEN_LO: begin
                    seg_len = {len_hi, b};
                    if (seg_len < 16'd2) begin
                        emit = 1'b1;
                        st   = jfsp_pkg::ST_NO_MARK;
                    end else begin
                        skip_left = seg_len - 16'd2;
                        phase     = (skip_left == 16'd0) ? jfsp_pkg::PH_MARK_FF
                                                         : jfsp_pkg::PH_SKIP;
                    end
                end
                jfsp_pkg::PH_FRAME: begin
                    if (sof_idx == 3'd3 || sof_idx == 3'd4) begin
                        height_acc = {height_acc[7:0], b};
                    end else if (sof_idx == 3'd5 || sof_idx == 3'd6) begin
                        width_acc = {width_acc[7:0], b};
                    end
                    if (sof_idx >= 3'd6) begin
                        emit = 1'b1;
                        st   = jfsp_pkg::ST_FOUND;
                        h    = height_acc;
                        w    = width_acc;
                    end
                    sof_idx = sof_idx + 3'd1;
                end
                default: ;
            endcase
            if (emit) begin
                done  = 1'b1;
                phase = jfsp_pkg::PH_DONE;
            end else if (last) begin
                emit = 1'b1;
                st   = jfsp_pkg::ST_ENDED;
            end
        end
        if (last) rearm();
        if (emit) begin
            rec.status = st;
            rec.width  = w;
            rec.height = h;
            expected_sizes.insert(expected_sizes.size(), rec);
        end
    endfunction

    function void check_report(logic [jfsp_pkg::M_TDATA_W-1:0] beat);
        frame_size_t want;
        if (expected_sizes.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual status %0d width %0d height %0d",
                     $time, beat[2:0], beat[18:3], beat[34:19]);
            errors++;
            return;
        end
        want = expected_sizes.pop_front();
        if (beat[2:0] != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, beat[2:0]);
            errors++;
        end
        if (beat[18:3] != want.width) begin
            $display("%0t: width expected %0d actual %0d", $time, want.width, beat[18:3]);
            errors++;
        end
        if (beat[34:19] != want.height) begin
            $display("%0t: height expected %0d actual %0d", $time, want.height, beat[34:19]);
            errors++;
        end
        if (beat[39:35] != 5'd0) begin
            $display("%0t: pad bits expected 0 actual %0h", $time, beat[39:35]);
            errors++;
        end
    endfunction

    function int leftover();
        if (expected_sizes.size() != 0) begin
            $display("%0t: %0d results expected, actual none", $time, expected_sizes.size());
        end
        return expected_sizes.size();
    endfunction
endclass

module jpeg_frame_size_parser_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 1250;
    localparam int JFIF_ID = 32'h4A46_4946;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [jfsp_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [jfsp_pkg::M_TDATA_W-1:0] m_tdata;

    logic                 hold_req = 1'b0;
    int                   hold_left = 0;
    logic [7:0]           rx_cycle = '0;
    int                   cycle_count = 0;

    size_checker          sizes;
    logic [7:0]           file_bytes[$];
    int                   file_cap;
    int                   sent_bytes = 0;
    int                   burst_left = 0;
    bit                   gaps_on = 1'b1;

    jpeg_frame_size_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sizes.check_report(m_tdata);
        if (hold_req) begin
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 8'd1;
            case (rx_cycle[7:6])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= (rx_cycle[1:0] == 2'b11);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left > 0) burst_left--;
        s_tdata  <= b;
        s_tlast  <= l;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sizes.take_byte(b, l);
        sent_bytes++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
        file_bytes.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sizes.expected_sizes.size() != 0);
    endtask

    function automatic void start_file(input int cap);
        file_cap = cap;
        file_bytes.delete();
    endfunction

    function automatic void put(input logic [7:0] b);
        if (file_bytes.size() < file_cap) file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void put_noise(input int n);
        for (int i = 0; i < n; i++) put(8'($urandom));
    endfunction

    function automatic void put_header(input int len, input int ident);
        put(8'hFF);
        put(8'hD8);
        put(8'hFF);
        put(8'hE0);
        put(8'(len >> 8));
        put(8'(len));
        put(8'(ident >> 24));
        put(8'(ident >> 16));
        put(8'(ident >> 8));
        put(8'(ident));
        put(8'h00);
        for (int i = 7; i < len && file_bytes.size() < file_cap; i++) put(8'($urandom));
    endfunction

    function automatic void put_segment(input logic [7:0] id, input int len);
        put(8'hFF);
        put(id);
        put(8'(len >> 8));
        put(8'(len));
        for (int i = 2; i < len && file_bytes.size() < file_cap; i++) put(8'($urandom));
    endfunction

    function automatic void put_frame(input logic [7:0] id, input logic [15:0] h,
                                      input logic [15:0] w);
        put(8'hFF);
        put(id);
        put(8'h00);
        put(8'h11);
        put(8'h08);
        put(h[15:8]);
        put(h[7:0]);
        put(w[15:8]);
        put(w[7:0]);
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_directed();
        start_file(4096);
        put_header(16, JFIF_ID);
        put_segment(8'hDB, 5);
        put_frame(8'hC0, 16'hFFFF, 16'hFFFF);
        put_noise(3);
        send_file();
        // decision on the very last byte
        start_file(4096);
        put_header(7, JFIF_ID);
        put_frame(8'hCF, 16'h0000, 16'h0000);
        send_file();
        // excluded C4/C8/CC and neighbours of the SOF range are skipped
        start_file(4096);
        put_header(16, JFIF_ID);
        put_segment(8'hC4, 2);
        put_segment(8'hC8, 4);
        put_segment(8'hCC, 3);
        put_segment(8'hBF, 2);
        put_segment(8'hD0, 2);
        put_frame(8'hC3, 16'h1234, 16'hABCD);
        put_noise(2);
        send_file();
        start_file(4096);
        put(8'h00);
        send_file();
        start_file(4096);
        put(8'hFF);
        put(8'hD8);
        put(8'hFF);
        put(8'hE1);
        put_noise(4);
        send_file();
        start_file(4096);
        put_header(16, 32'h4A46_4958);
        send_file();
        // identifier is checked before the short length
        start_file(4096);
        put_header(3, 32'h4A46_4945);
        send_file();
        start_file(4096);
        put_header(6, JFIF_ID);
        put_noise(3);
        send_file();
        start_file(4096);
        put_header(9, JFIF_ID);
        put(8'h12);
        put_noise(2);
        send_file();
        start_file(4096);
        put_header(16, JFIF_ID);
        put_segment(8'hE1, 0);
        send_file();
        start_file(4096);
        put_header(8, JFIF_ID);
        put_segment(8'hE2, 1);
        put_noise(1);
        send_file();
        start_file(4096);
        put_header(16'h0110, JFIF_ID);
        put_frame(8'hC1, 16'd480, 16'd640);
        send_file();
        // stream ends inside the SOF segment
        start_file(26);
        put_header(16, JFIF_ID);
        put_frame(8'hC2, 16'h5555, 16'hAAAA);
        send_file();
        start_file(5);
        put_header(16, JFIF_ID);
        send_file();
        start_file(40);
        put_header(16'hFFFF, JFIF_ID);
        send_file();
        start_file(64);
        put_header(7, JFIF_ID);
        put_segment(8'hE0, 16'hFF02);
        send_file();
    endtask

    task automatic random_file();
        int          kind;
        int          hlen;
        int          slen;
        int          nseg;
        logic [7:0]  id;
        int          ident;
        logic [15:0] h;
        logic [15:0] w;
        kind    = $urandom_range(0, 9);
        gaps_on = ($urandom_range(0, 4) != 0);
        start_file(($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : 120);
        if (kind < 7) begin
            case ($urandom_range(0, 9))
                0:       hlen = $urandom_range(0, 8);
                1:       hlen = $urandom_range(0, 65535);
                default: hlen = $urandom_range(7, 20);
            endcase
            ident = ($urandom_range(0, 15) == 0) ? int'($urandom) : JFIF_ID;
            put_header(hlen, ident);
            nseg = $urandom_range(0, 2);
            for (int i = 0; i < nseg; i++) begin
                case ($urandom_range(0, 3))
                    0:       id = 8'($urandom);
                    1:       id = 8'hC4 + 8'(4 * $urandom_range(0, 2));
                    2:       id = 8'hE0 + 8'($urandom_range(0, 15));
                    default: id = 8'hDB;
                endcase
                case ($urandom_range(0, 9))
                    0:       slen = $urandom_range(0, 1);
                    1:       slen = $urandom_range(0, 65535);
                    default: slen = $urandom_range(2, 10);
                endcase
                put_segment(id, slen);
            end
            do id = 8'hC0 + 8'($urandom_range(0, 15));
            while (id == 8'hC4 || id == 8'hC8 || id == 8'hCC);
            h = pick_dim();
            w = pick_dim();
            put_frame(id, h, w);
            put_noise($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0 && file_bytes.size() != 0) begin
                file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
            end
        end else if (kind < 9) begin
            file_cap = $urandom_range(1, 16);
            put_header($urandom_range(0, 20), JFIF_ID);
            if ($urandom_range(0, 1) == 0) begin
                file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
            end
        end else begin
            put_noise($urandom_range(1, 12));
        end
        send_file();
    endtask

    initial begin
        int  rand_goal;
        bit  paused;
        sizes = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        wait_drained();
        // hold the result side off while short files keep arriving
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        gaps_on = 1'b0;
        repeat (12) begin
            start_file(4096);
            put(8'h00);
            put(8'($urandom));
            send_file();
        end
        wait_drained();
        rand_goal = sent_bytes + RANDOM_BYTES;
        paused    = 1'b0;
        while (sent_bytes < rand_goal) begin
            random_file();
            if (!paused && sent_bytes > rand_goal - RANDOM_BYTES / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();
        repeat (20) @(posedge aclk);
        if (sizes.errors == 0 && sizes.leftover() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
